FILE: rtl/core/biarc_knot_solver_assert.svh
// Assertion macros used by the solver core
`ifndef BIARC_KNOT_SOLVER_ASSERT_SVH
`define BIARC_KNOT_SOLVER_ASSERT_SVH

// cond must hold whenever trig holds
`define BKS_ASSERT_IMPLY(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// cond must never hold
`define BKS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: rtl/core/bks_pkg.sv
`default_nettype none
package bks_pkg;

   localparam int POS_W             = 24;
   localparam int ANG_W             = 16;
   localparam int TRIG_W            = 16;
   localparam int TAB_LEN           = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int SC_W     = 34;
   localparam int SC_AW    = 34;
   localparam int VEC_W    = 57;
   localparam int VEC_AW   = 34;

   localparam int B_W      = 27;
   localparam int MB_W     = 26;
   localparam int V_W      = 48;
   localparam int A_W      = 17;
   localparam int AC_W     = 16;
   localparam int RAD_W    = 52;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int SQ_REM_W = ROOT_W + 4;
   localparam int NUM_W    = 48;
   localparam int DEN_W    = 27;
   localparam int DV_REM_W = DEN_W + 1;
   localparam int DM_W     = 41;

   localparam logic [DM_W-1:0] D_LIMIT = DM_W'(64'h100_0000_0000);
   localparam int CORDIC_K = 652032874;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic                    zero;
      logic                    neg;
   } sc_side_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic                     zero;
      logic                     use_v;
      logic                     d_neg;
      logic [MB_W-1:0]          mb;
      logic [V_W-1:0]           v;
      logic [A_W-1:0]           a;
      logic signed [TRIG_W-1:0] s;
      logic [AC_W-1:0]          ac;
   } sq_side_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
      logic                     zero;
      logic                     use_v;
      logic                     d_neg;
      logic                     dz;
      logic signed [TRIG_W-1:0] s;
      logic [AC_W-1:0]          ac;
   } dv_side_type;

   typedef struct packed {
      logic signed [POS_W-1:0] kx;
      logic signed [POS_W-1:0] ky;
      logic                    origin;
   } at_side_type;

   function automatic logic [33:0] atan_entry(input int idx);
      logic [33:0] v;
      unique case (idx)
         0:  v = 34'h20000000;
         1:  v = 34'h12E4051E;
         2:  v = 34'h09FB385B;
         3:  v = 34'h051111D4;
         4:  v = 34'h028B0D43;
         5:  v = 34'h0145D7E1;
         6:  v = 34'h00A2F61E;
         7:  v = 34'h00517C55;
         8:  v = 34'h0028BE53;
         9:  v = 34'h00145F2F;
         10: v = 34'h000A2F98;
         11: v = 34'h000517CC;
         12: v = 34'h00028BE6;
         13: v = 34'h000145F3;
         14: v = 34'h0000A2FA;
         15: v = 34'h0000517D;
         16: v = 34'h000028BE;
         17: v = 34'h0000145F;
         18: v = 34'h00000A30;
         19: v = 34'h00000518;
         20: v = 34'h0000028C;
         21: v = 34'h00000146;
         22: v = 34'h000000A3;
         23: v = 34'h00000051;
         default: v = 34'h0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bks_cordic_cell.sv
`default_nettype none
module bks_cordic_cell #(
   parameter int W         = 34,
   parameter int AW        = 34,
   parameter int STAGE     = 0,
   parameter bit VECTORING = 1'b0,
   parameter int SW        = 1
) (
   input  wire logic                 clock,
   input  wire logic signed [W-1:0]  src_x,
   input  wire logic signed [W-1:0]  src_y,
   input  wire logic signed [AW-1:0] src_ang,
   input  wire logic [SW-1:0]        src_side,
   output logic signed [W-1:0]       dst_x,
   output logic signed [W-1:0]       dst_y,
   output logic signed [AW-1:0]      dst_ang,
   output logic [SW-1:0]             dst_side
);
   import bks_pkg::*;

   localparam logic signed [AW-1:0] ATAN = $signed(AW'(atan_entry(STAGE)));

   logic signed [W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0] ang_ff, ang_in;
   logic [SW-1:0]        side_ff;
   logic                 up;

   always_comb begin
      up     = VECTORING ? src_y[W-1] : !src_ang[AW-1];
      x_in   = up ? src_x - (src_y >>> STAGE) : src_x + (src_y >>> STAGE);
      y_in   = up ? src_y + (src_x >>> STAGE) : src_y - (src_x >>> STAGE);
      ang_in = up ? src_ang - ATAN : src_ang + ATAN;
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      ang_ff  <= ang_in;
      side_ff <= src_side;
   end

   assign dst_x    = x_ff;
   assign dst_y    = y_ff;
   assign dst_ang  = ang_ff;
   assign dst_side = side_ff;
endmodule
`default_nettype wire

FILE: rtl/core/bks_sqrt_cell.sv
`default_nettype none
module bks_sqrt_cell #(
   parameter int RAD_W  = 52,
   parameter int ROOT_W = 26,
   parameter int REM_W  = 30,
   parameter int SW     = 1
) (
   input  wire logic              clock,
   input  wire logic [RAD_W-1:0]  src_rad,
   input  wire logic [REM_W-1:0]  src_rem,
   input  wire logic [ROOT_W-1:0] src_root,
   input  wire logic [SW-1:0]     src_side,
   output logic [RAD_W-1:0]       dst_rad,
   output logic [REM_W-1:0]       dst_rem,
   output logic [ROOT_W-1:0]      dst_root,
   output logic [SW-1:0]          dst_side
);
   import bks_pkg::*;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_new, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SW-1:0]     side_ff;
   logic              ge;

   always_comb begin
      rem_new = {src_rem[REM_W-3:0], src_rad[RAD_W-1:RAD_W-2]};
      trial   = REM_W'({src_root, 2'b01});
      ge      = rem_new >= trial;
      rem_in  = ge ? rem_new - trial : rem_new;
      root_in = {src_root[ROOT_W-2:0], ge};
      rad_in  = {src_rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= src_side;
   end

   assign dst_rad  = rad_ff;
   assign dst_rem  = rem_ff;
   assign dst_root = root_ff;
   assign dst_side = side_ff;
endmodule
`default_nettype wire

FILE: rtl/core/bks_div_cell.sv
`default_nettype none
module bks_div_cell #(
   parameter int NW = 48,
   parameter int DW = 27,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic [NW-1:0] src_num,
   input  wire logic [DW:0]   src_rem,
   input  wire logic [DW-1:0] src_den,
   input  wire logic [NW-1:0] src_quo,
   input  wire logic [SW-1:0] src_side,
   output logic [NW-1:0]      dst_num,
   output logic [DW:0]        dst_rem,
   output logic [DW-1:0]      dst_den,
   output logic [NW-1:0]      dst_quo,
   output logic [SW-1:0]      dst_side
);
   import bks_pkg::*;

   logic [NW-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [DW:0]   rem_ff, rem_in, rem_new;
   logic [DW-1:0] den_ff;
   logic [SW-1:0] side_ff;
   logic          ge;

   always_comb begin
      rem_new = {src_rem[DW-1:0], src_num[NW-1]};
      ge      = rem_new >= (DW+1)'(src_den);
      rem_in  = ge ? rem_new - (DW+1)'(src_den) : rem_new;
      quo_in  = {src_quo[NW-2:0], ge};
      num_in  = {src_num[NW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= src_den;
      quo_ff  <= quo_in;
      side_ff <= src_side;
   end

   assign dst_num  = num_ff;
   assign dst_rem  = rem_ff;
   assign dst_den  = den_ff;
   assign dst_quo  = quo_ff;
   assign dst_side = side_ff;
endmodule
`default_nettype wire

FILE: rtl/core/biarc_knot_solver.sv
`default_nettype none
// Channel   Ports                                     Handshake
// request   req_target_x/y/heading                    start, busy (always low)
// result    rsp_knot_x/y/heading                      rsp_valid, one-cycle strobe
//
// One request per cycle, no kept state between requests.
// The pipeline holds two CORDIC chains, a 26-cell
// square root chain, a 48-cell divider chain and 14 pipeline registers.
// Synchronous reset clears only the valid pipe; payload registers are not reset.
// The receiver cannot stall: every result is shown for exactly one cycle.
module biarc_knot_solver #(
   parameter int CORDIC_STAGES = bks_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic signed [bks_pkg::POS_W-1:0]   req_target_x,
   input  wire logic signed [bks_pkg::POS_W-1:0]   req_target_y,
   input  wire logic signed [bks_pkg::ANG_W-1:0]   req_target_heading,
   output logic                                    rsp_valid,
   output logic signed [bks_pkg::POS_W-1:0]        rsp_knot_x,
   output logic signed [bks_pkg::POS_W-1:0]        rsp_knot_y,
   output logic signed [bks_pkg::ANG_W-1:0]        rsp_knot_heading
);
   import bks_pkg::*;
`include "biarc_knot_solver_assert.svh"

   localparam int N    = CORDIC_STAGES < TAB_LEN ? CORDIC_STAGES : TAB_LEN;
   localparam int LAT  = 14 + 2 * N + ROOT_W + NUM_W;
   localparam int SC_SW = $bits(sc_side_type);
   localparam int SQ_SW = $bits(sq_side_type);
   localparam int DV_SW = $bits(dv_side_type);
   localparam int AT_SW = $bits(at_side_type);
   localparam int XS_W = POS_W + TRIG_W;
   localparam int YC_W = POS_W + AC_W + 1;
   localparam int SUM_W = YC_W + 1;
   localparam int XX_W = 2 * POS_W;
   localparam int P_W  = 37;
   localparam int PS_W = 57;
   localparam int T_W  = 59;
   localparam int KF_W = T_W - 15;
   localparam int LO_W = 21;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [KF_W-1:0] v);
      logic signed [POS_W-1:0] r;
      priority if (v > KF_W'(8388607)) r = POS_W'(8388607);
      else if (v < -KF_W'(8388608)) r = POS_W'(-8388608);
      else r = POS_W'(v);
      return r;
   endfunction

   function automatic logic signed [TRIG_W-1:0] round_trig(input logic signed [SC_W-1:0] v);
      logic signed [SC_W-1:0] t;
      logic signed [TRIG_W-1:0] r;
      t = (v + SC_W'(32768)) >>> 16;
      priority if (t > SC_W'(16384)) r = TRIG_W'(16384);
      else if (t < -SC_W'(16384)) r = -TRIG_W'(16384);
      else r = TRIG_W'(t);
      return r;
   endfunction

   logic [LAT-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start};
      end
   end

   assign busy      = 1'b0;
   assign rsp_valid = valid_ff[LAT-1];

   // P1: capture request, fold angle into the right half plane
   logic signed [POS_W-1:0] p1_x_ff, p1_y_ff;
   logic signed [ANG_W-1:0] p1_h_ff;
   logic signed [SC_AW-1:0] z0, z_in;
   logic                    neg_in;
   sc_side_type             sc_head, sc_tail;

   always_ff @(posedge clock) begin
      p1_x_ff <= req_target_x;
      p1_y_ff <= req_target_y;
      p1_h_ff <= req_target_heading;
   end

   always_comb begin
      z0 = SC_AW'($signed({p1_h_ff, 16'h0000}));
      priority if (z0 > SC_AW'(64'sd1073741824)) begin
         z_in   = z0 - SC_AW'(64'sd2147483648);
         neg_in = 1'b1;
      end else if (z0 < -SC_AW'(64'sd1073741824)) begin
         z_in   = z0 + SC_AW'(64'sd2147483648);
         neg_in = 1'b1;
      end else begin
         z_in   = z0;
         neg_in = 1'b0;
      end
      sc_head.x    = p1_x_ff;
      sc_head.y    = p1_y_ff;
      sc_head.zero = p1_h_ff == '0;
      sc_head.neg  = neg_in;
   end

   logic signed [SC_W-1:0]  sc_x [0:N];
   logic signed [SC_W-1:0]  sc_y [0:N];
   logic signed [SC_AW-1:0] sc_z [0:N];
   logic [SC_SW-1:0]        sc_side [0:N];

   assign sc_x[0]    = SC_W'(CORDIC_K);
   assign sc_y[0]    = '0;
   assign sc_z[0]    = z_in;
   assign sc_side[0] = sc_head;

   for (genvar gi = 0; gi < N; gi++) begin : g_sc
      bks_cordic_cell #(
         .W(SC_W), .AW(SC_AW), .STAGE(gi), .VECTORING(1'b0), .SW(SC_SW)
      ) u_cell (
         .clock(clock),
         .src_x(sc_x[gi]), .src_y(sc_y[gi]), .src_ang(sc_z[gi]), .src_side(sc_side[gi]),
         .dst_x(sc_x[gi+1]), .dst_y(sc_y[gi+1]), .dst_ang(sc_z[gi+1]),
         .dst_side(sc_side[gi+1])
      );
   end

   assign sc_tail = sc_side[N];

   // P2: round sin and cos
   logic signed [TRIG_W-1:0] p2_s_ff, p2_c_ff, cr, sr;
   logic signed [POS_W-1:0]  p2_x_ff, p2_y_ff;
   logic                     p2_zero_ff;

   always_comb begin
      cr = round_trig(sc_x[N]);
      sr = round_trig(sc_y[N]);
   end

   always_ff @(posedge clock) begin
      p2_s_ff    <= sc_tail.neg ? -sr : sr;
      p2_c_ff    <= sc_tail.neg ? -cr : cr;
      p2_x_ff    <= sc_tail.x;
      p2_y_ff    <= sc_tail.y;
      p2_zero_ff <= sc_tail.zero;
   end

   // P3: products for B and V
   logic signed [XS_W-1:0]   p3_xs_ff;
   logic signed [YC_W-1:0]   p3_yc_ff;
   logic [XX_W-1:0]          p3_xx_ff, p3_yy_ff;
   logic [A_W-1:0]           p3_a_ff;
   logic [AC_W-1:0]          p3_ac_ff;
   logic signed [TRIG_W-1:0] p3_s_ff;
   logic signed [POS_W-1:0]  p3_x_ff, p3_y_ff;
   logic                     p3_zero_ff;
   logic [AC_W-1:0]          cp;
   logic signed [A_W:0]      acw;

   always_comb begin
      cp  = AC_W'(AC_W'(16384) + AC_W'(p2_c_ff));
      acw = (A_W+1)'(16384) - (A_W+1)'(p2_c_ff);
   end

   always_ff @(posedge clock) begin
      p3_xs_ff   <= XS_W'(p2_x_ff) * XS_W'(p2_s_ff);
      p3_yc_ff   <= YC_W'(p2_y_ff) * $signed(YC_W'({1'b0, cp}));
      p3_xx_ff   <= XX_W'(XX_W'(p2_x_ff) * XX_W'(p2_x_ff));
      p3_yy_ff   <= XX_W'(XX_W'(p2_y_ff) * XX_W'(p2_y_ff));
      p3_a_ff    <= A_W'({acw[A_W-1:0], 1'b0});
      p3_ac_ff   <= AC_W'(acw);
      p3_s_ff    <= p2_s_ff;
      p3_x_ff    <= p2_x_ff;
      p3_y_ff    <= p2_y_ff;
      p3_zero_ff <= p2_zero_ff;
   end

   // P4: B and V
   logic signed [B_W-1:0]    p4_b_ff;
   logic [V_W-1:0]           p4_v_ff;
   logic [A_W-1:0]           p4_a_ff;
   logic [AC_W-1:0]          p4_ac_ff;
   logic signed [TRIG_W-1:0] p4_s_ff;
   logic signed [POS_W-1:0]  p4_x_ff, p4_y_ff;
   logic                     p4_zero_ff;
   logic signed [SUM_W-1:0]  bsum;

   always_comb begin
      bsum = SUM_W'(p3_xs_ff) + SUM_W'(p3_yc_ff) + SUM_W'(8192);
   end

   always_ff @(posedge clock) begin
      p4_b_ff    <= B_W'(bsum >>> 14);
      p4_v_ff    <= V_W'(p3_xx_ff) + V_W'(p3_yy_ff);
      p4_a_ff    <= p3_a_ff;
      p4_ac_ff   <= p3_ac_ff;
      p4_s_ff    <= p3_s_ff;
      p4_x_ff    <= p3_x_ff;
      p4_y_ff    <= p3_y_ff;
      p4_zero_ff <= p3_zero_ff;
   end

   // P5: magnitude, square and partial A*V
   logic [MB_W-1:0]          mb_in;
   logic                     ypos;
   logic [2*MB_W-1:0]        p5_mb2_ff;
   logic [A_W+23:0]          p5_avlo_ff, p5_avhi_ff;
   sq_side_type              p5_side_ff;

   always_comb begin
      mb_in = p4_b_ff[B_W-1] ? MB_W'(-p4_b_ff) : MB_W'(p4_b_ff);
      ypos  = !p4_y_ff[POS_W-1] && (p4_y_ff != '0);
   end

   always_ff @(posedge clock) begin
      p5_mb2_ff        <= (2*MB_W)'(mb_in) * (2*MB_W)'(mb_in);
      p5_avlo_ff       <= (A_W+24)'(p4_a_ff) * (A_W+24)'(p4_v_ff[23:0]);
      p5_avhi_ff       <= (A_W+24)'(p4_a_ff) * (A_W+24)'(p4_v_ff[V_W-1:24]);
      p5_side_ff.x     <= p4_x_ff;
      p5_side_ff.y     <= p4_y_ff;
      p5_side_ff.zero  <= p4_zero_ff;
      p5_side_ff.use_v <= ypos ? !p4_b_ff[B_W-1] : (p4_b_ff[B_W-1] || p4_b_ff == '0);
      p5_side_ff.d_neg <= !ypos;
      p5_side_ff.mb    <= mb_in;
      p5_side_ff.v     <= p4_v_ff;
      p5_side_ff.a     <= p4_a_ff;
      p5_side_ff.s     <= p4_s_ff;
      p5_side_ff.ac    <= p4_ac_ff;
   end

   // P6: assemble A*V
   logic [63:0]       p6_av_ff;
   logic [2*MB_W-1:0] p6_mb2_ff;
   sq_side_type       p6_side_ff;

   always_ff @(posedge clock) begin
      p6_av_ff   <= 64'({p5_avhi_ff, 24'h000000}) + 64'(p5_avlo_ff);
      p6_mb2_ff  <= p5_mb2_ff;
      p6_side_ff <= p5_side_ff;
   end

   // P7: radicand
   logic [RAD_W-1:0] p7_rad_ff;
   sq_side_type      p7_side_ff;

   always_ff @(posedge clock) begin
      p7_rad_ff  <= RAD_W'(RAD_W'(p6_mb2_ff) + RAD_W'(p6_av_ff >> 14));
      p7_side_ff <= p6_side_ff;
   end

   logic [RAD_W-1:0]    sq_rad  [0:ROOT_W];
   logic [SQ_REM_W-1:0] sq_rem  [0:ROOT_W];
   logic [ROOT_W-1:0]   sq_root [0:ROOT_W];
   logic [SQ_SW-1:0]    sq_side [0:ROOT_W];
   sq_side_type         sq_tail;

   assign sq_rad[0]  = p7_rad_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = p7_side_ff;

   for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_sq
      bks_sqrt_cell #(
         .RAD_W(RAD_W), .ROOT_W(ROOT_W), .REM_W(SQ_REM_W), .SW(SQ_SW)
      ) u_cell (
         .clock(clock),
         .src_rad(sq_rad[gi]), .src_rem(sq_rem[gi]), .src_root(sq_root[gi]),
         .src_side(sq_side[gi]),
         .dst_rad(sq_rad[gi+1]), .dst_rem(sq_rem[gi+1]), .dst_root(sq_root[gi+1]),
         .dst_side(sq_side[gi+1])
      );
   end

   assign sq_tail = sq_side[ROOT_W];

   // P8: pick quotient operands
   logic [DEN_W-1:0] rsum, den_in;
   logic [NUM_W-1:0] p8_num_ff;
   logic [DEN_W-1:0] p8_den_ff;
   dv_side_type      p8_side_ff;

   always_comb begin
      rsum   = DEN_W'(sq_tail.mb) + DEN_W'(sq_root[ROOT_W]);
      den_in = sq_tail.use_v ? rsum : DEN_W'(sq_tail.a);
   end

   always_ff @(posedge clock) begin
      p8_num_ff        <= sq_tail.use_v ? sq_tail.v : NUM_W'({rsum, 14'h0000});
      p8_den_ff        <= den_in;
      p8_side_ff.x     <= sq_tail.x;
      p8_side_ff.y     <= sq_tail.y;
      p8_side_ff.zero  <= sq_tail.zero;
      p8_side_ff.use_v <= sq_tail.use_v;
      p8_side_ff.d_neg <= sq_tail.d_neg;
      p8_side_ff.dz    <= den_in == '0;
      p8_side_ff.s     <= sq_tail.s;
      p8_side_ff.ac    <= sq_tail.ac;
   end

   logic [NUM_W-1:0] dv_num  [0:NUM_W];
   logic [DEN_W:0]   dv_rem  [0:NUM_W];
   logic [DEN_W-1:0] dv_den  [0:NUM_W];
   logic [NUM_W-1:0] dv_quo  [0:NUM_W];
   logic [DV_SW-1:0] dv_side [0:NUM_W];
   dv_side_type      dv_tail;

   assign dv_num[0]  = p8_num_ff;
   assign dv_rem[0]  = '0;
   assign dv_den[0]  = p8_den_ff;
   assign dv_quo[0]  = '0;
   assign dv_side[0] = p8_side_ff;

   for (genvar gi = 0; gi < NUM_W; gi++) begin : g_dv
      bks_div_cell #(
         .NW(NUM_W), .DW(DEN_W), .SW(DV_SW)
      ) u_cell (
         .clock(clock),
         .src_num(dv_num[gi]), .src_rem(dv_rem[gi]), .src_den(dv_den[gi]),
         .src_quo(dv_quo[gi]), .src_side(dv_side[gi]),
         .dst_num(dv_num[gi+1]), .dst_rem(dv_rem[gi+1]), .dst_den(dv_den[gi+1]),
         .dst_quo(dv_quo[gi+1]), .dst_side(dv_side[gi+1])
      );
   end

   assign dv_tail = dv_side[NUM_W];

   // P9: clamp d
   logic [DM_W-1:0] p9_dm_ff, dm_in;
   dv_side_type     p9_side_ff;

   always_comb begin
      priority if (dv_tail.dz) dm_in = dv_tail.use_v ? '0 : D_LIMIT;
      else if (dv_quo[NUM_W] > NUM_W'(D_LIMIT)) dm_in = D_LIMIT;
      else dm_in = DM_W'(dv_quo[NUM_W]);
   end

   always_ff @(posedge clock) begin
      p9_dm_ff   <= dm_in;
      p9_side_ff <= dv_tail;
   end

   // P10: partial products of d
   logic signed [P_W-1:0] p10_pslo_ff, p10_pshi_ff;
   logic [P_W-1:0]        p10_pclo_ff, p10_pchi_ff;
   dv_side_type           p10_side_ff;

   always_ff @(posedge clock) begin
      p10_pslo_ff <= $signed(P_W'(p9_dm_ff[LO_W-1:0])) * P_W'(p9_side_ff.s);
      p10_pshi_ff <= $signed(P_W'(p9_dm_ff[DM_W-1:LO_W])) * P_W'(p9_side_ff.s);
      p10_pclo_ff <= P_W'(p9_dm_ff[LO_W-1:0]) * P_W'(p9_side_ff.ac);
      p10_pchi_ff <= P_W'(p9_dm_ff[DM_W-1:LO_W]) * P_W'(p9_side_ff.ac);
      p10_side_ff <= p9_side_ff;
   end

   // P11: assemble d*S and d*(1-C)
   logic signed [PS_W-1:0] p11_ps_ff;
   logic [PS_W-1:0]        p11_pc_ff;
   dv_side_type            p11_side_ff;

   always_ff @(posedge clock) begin
      p11_ps_ff   <= (PS_W'(p10_pshi_ff) <<< LO_W) + PS_W'(p10_pslo_ff);
      p11_pc_ff   <= (PS_W'(p10_pchi_ff) << LO_W) + PS_W'(p10_pclo_ff);
      p11_side_ff <= p10_side_ff;
   end

   // P12: knot position
   logic signed [T_W-1:0]   xt, yt, kxt, kyt;
   logic signed [POS_W:0]   hx, hy;
   logic signed [POS_W-1:0] p12_kx_ff, p12_ky_ff;

   always_comb begin
      xt  = (T_W'(p11_side_ff.x) <<< 14) + T_W'(16384);
      yt  = (T_W'(p11_side_ff.y) <<< 14) + T_W'(16384);
      kxt = p11_side_ff.d_neg ? xt + T_W'(p11_ps_ff) : xt - T_W'(p11_ps_ff);
      kyt = p11_side_ff.d_neg ? yt - $signed(T_W'(p11_pc_ff))
                              : yt + $signed(T_W'(p11_pc_ff));
      hx  = ((POS_W+1)'(p11_side_ff.x) + (POS_W+1)'(1)) >>> 1;
      hy  = ((POS_W+1)'(p11_side_ff.y) + (POS_W+1)'(1)) >>> 1;
   end

   always_ff @(posedge clock) begin
      p12_kx_ff <= p11_side_ff.zero ? POS_W'(hx) : sat_pos(KF_W'(kxt >>> 15));
      p12_ky_ff <= p11_side_ff.zero ? POS_W'(hy) : sat_pos(KF_W'(kyt >>> 15));
   end

   // P13: turn the knot vector into the right half plane
   logic signed [POS_W:0]    re_in, im_in;
   logic signed [VEC_AW-1:0] acc_in;
   logic signed [VEC_W-1:0]  p13_re_ff, p13_im_ff;
   logic signed [VEC_AW-1:0] p13_acc_ff;
   at_side_type              p13_side_ff;

   always_comb begin
      priority if (p12_ky_ff[POS_W-1] && !p12_kx_ff[POS_W-1]) begin
         re_in  = (POS_W+1)'(p12_kx_ff);
         im_in  = -(POS_W+1)'(p12_ky_ff);
         acc_in = VEC_AW'(64'sd1073741824);
      end else if (p12_ky_ff[POS_W-1]) begin
         re_in  = -(POS_W+1)'(p12_kx_ff);
         im_in  = (POS_W+1)'(p12_ky_ff);
         acc_in = -VEC_AW'(64'sd1073741824);
      end else begin
         re_in  = (POS_W+1)'(p12_ky_ff);
         im_in  = (POS_W+1)'(p12_kx_ff);
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      p13_re_ff          <= VEC_W'(re_in) <<< 30;
      p13_im_ff          <= VEC_W'(im_in) <<< 30;
      p13_acc_ff         <= acc_in;
      p13_side_ff.kx     <= p12_kx_ff;
      p13_side_ff.ky     <= p12_ky_ff;
      p13_side_ff.origin <= (p12_kx_ff == '0) && (p12_ky_ff == '0);
   end

   logic signed [VEC_W-1:0]  at_re   [0:N];
   logic signed [VEC_W-1:0]  at_im   [0:N];
   logic signed [VEC_AW-1:0] at_acc  [0:N];
   logic [AT_SW-1:0]         at_side [0:N];
   at_side_type              at_tail;

   assign at_re[0]   = p13_re_ff;
   assign at_im[0]   = p13_im_ff;
   assign at_acc[0]  = p13_acc_ff;
   assign at_side[0] = p13_side_ff;

   for (genvar gi = 0; gi < N; gi++) begin : g_at
      bks_cordic_cell #(
         .W(VEC_W), .AW(VEC_AW), .STAGE(gi), .VECTORING(1'b1), .SW(AT_SW)
      ) u_cell (
         .clock(clock),
         .src_x(at_re[gi]), .src_y(at_im[gi]), .src_ang(at_acc[gi]),
         .src_side(at_side[gi]),
         .dst_x(at_re[gi+1]), .dst_y(at_im[gi+1]), .dst_ang(at_acc[gi+1]),
         .dst_side(at_side[gi+1])
      );
   end

   assign at_tail = at_side[N];

   // P14: result register
   logic [VEC_AW:0]         hsum;
   logic signed [POS_W-1:0] rsp_kx_ff, rsp_ky_ff;
   logic signed [ANG_W-1:0] rsp_h_ff;

   always_comb begin
      hsum = {at_acc[N], 1'b0} + (VEC_AW+1)'(32768);
   end

   always_ff @(posedge clock) begin
      rsp_kx_ff <= at_tail.kx;
      rsp_ky_ff <= at_tail.ky;
      rsp_h_ff  <= at_tail.origin ? '0 : $signed(hsum[31:16]);
   end

   assign rsp_knot_x       = rsp_kx_ff;
   assign rsp_knot_y       = rsp_ky_ff;
   assign rsp_knot_heading = rsp_h_ff;

   `BKS_ASSERT_IMPLY(a_rsp_follows_req, clock, reset, rsp_valid, $past(start, LAT), "result without request")
   `BKS_ASSERT_IMPLY(a_origin_heading, clock, reset, rsp_valid && rsp_knot_x == '0 && rsp_knot_y == '0, rsp_knot_heading == '0, "origin knot with non-zero heading")
   `BKS_ASSERT_IMPLY(a_trig_range, clock, reset, valid_ff[N+1], (p2_s_ff <= 16384) && (p2_s_ff >= -16384) && (p2_c_ff <= 16384) && (p2_c_ff >= -16384), "sine or cosine out of range")
endmodule
`default_nettype wire
